// ----- rtl/cctab_pkg.sv -----
// ----------------------------------------------------------------------------
// cctab_pkg
// Shared types, codes and helpers for the category/count histogram table.
// ----------------------------------------------------------------------------
package cctab_pkg;

  localparam int DEPTH_DEF = 256;

  // Command codes
  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_SET     = 3'd1;
  localparam logic [2:0] CMD_APPEND  = 3'd2;
  localparam logic [2:0] CMD_ZERO    = 3'd3;
  localparam logic [2:0] CMD_SORTCAT = 3'd4;
  localparam logic [2:0] CMD_SORTCNT = 3'd5;
  localparam logic [2:0] CMD_READ    = 3'd6;
  localparam logic [2:0] CMD_CLEAR   = 3'd7;

  // Status codes
  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_APPENDED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  typedef struct packed {
    logic signed [31:0] cat;
    logic signed [47:0] cnt;
    logic               dead;
  } entry_t;

  typedef enum logic [1:0] {
    KEY_CAT  = 2'd0,
    KEY_CNT  = 2'd1,
    KEY_DEAD = 2'd2
  } key_t;

  typedef struct packed {
    logic shift;
    logic sort;
    logic parity;
    key_t key;
  } cell_op_t;

  // Saturating 48-bit signed add
  function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                 input logic signed [47:0] b);
    logic [48:0] s;
    begin
      s = {a[47], a} + {b[47], b};
      if (s[48] != s[47]) begin
        sat_add = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
        sat_add = s[47:0];
      end
    end
  endfunction

endpackage

// ----- rtl/cctab_cell.sv -----
// ----------------------------------------------------------------------------
// cctab_cell
// One table slot: shifts toward the head in a ring pass, or swaps with its
// right neighbor in an odd/even transposition round.
// ----------------------------------------------------------------------------
module cctab_cell #(
  parameter int DEPTH = cctab_pkg::DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                       clk,
  input  cctab_pkg::cell_op_t        op,
  input  logic [$clog2(DEPTH+1)-1:0] total,
  input  cctab_pkg::entry_t          right,
  input  cctab_pkg::entry_t          left,
  input  logic                       swap_in,
  output logic                       swap_out,
  output cctab_pkg::entry_t          q
);
  import cctab_pkg::*;

  localparam int   TW  = $clog2(DEPTH + 1);
  localparam logic PAR = 1'(IDX % 2);

  logic ahead;
  logic pair_live;

  // Decide whether the right neighbor orders strictly ahead of this slot
  always_comb begin
    case (op.key)
      KEY_CAT:  ahead = right.cat < q.cat;
      KEY_CNT:  ahead = (right.cnt != q.cnt) ? (right.cnt < q.cnt) : (right.cat < q.cat);
      KEY_DEAD: ahead = q.dead && !right.dead;
      default:  ahead = 1'b0;
    endcase
    pair_live = (PAR == op.parity) && (TW'(IDX + 1) < total);
    swap_out  = op.sort && pair_live && ahead;
  end

  // Advance the ring or swap with a neighbor
  always_ff @(posedge clk) begin
    if (op.shift) begin
      q <= right;
    end else if (swap_out) begin
      q <= right;
    end else if (swap_in) begin
      q <= left;
    end
  end

endmodule

// ----- rtl/category_count_histogram_table_unit.sv -----
// Sequence per item: add, set, append, zero counts and read make one ring pass; sort by count
// runs transposition rounds; sort by category runs sort rounds, a merge pass and compaction
// rounds; clear, or a sort of at most one entry, goes straight to the finish state.
// One item at a time: a new item is accepted only after the last result is loaded into the
// output register, and a stalled result that is still held delays that load.
// Reset clears the entry count and control; cell contents are undefined until written.
// ----------------------------------------------------------------------------
// category_count_histogram_table_unit
// Histogram table of (category, count) pairs held in a row of cells.
// ----------------------------------------------------------------------------
module category_count_histogram_table_unit #(
  parameter int DEPTH = cctab_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command,
  input  logic signed [31:0] entry_category,
  input  logic signed [47:0] entry_count,
  input  logic [7:0]         entry_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [31:0] read_category,
  output logic signed [47:0] read_count,
  output logic [8:0]         entries_used
);
  import cctab_pkg::*;

  localparam int TW = $clog2(DEPTH + 1);
  localparam int KW = $clog2(DEPTH);
  localparam int CW = (TW > 8) ? TW : 8;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_SORT  = 6'b000100,
    S_MERGE = 6'b001000,
    S_PACK  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t             state;
  logic [2:0]         cmd;
  logic signed [31:0] cat_r;
  logic signed [47:0] cnt_r;
  logic [7:0]         idx_r;
  logic [TW-1:0]      total;
  logic [KW-1:0]      k;
  logic               found;
  logic signed [31:0] acc_cat;
  logic signed [47:0] acc_cnt;
  logic [TW-1:0]      alive;
  logic [2:0]         st_r;
  logic signed [31:0] rcat;
  logic signed [47:0] rcnt;

  entry_t   q   [DEPTH];
  logic     swp [DEPTH];
  entry_t   ins;
  cell_op_t op;

  logic          last;
  logic          in_tab;
  logic          at_tot;
  logic          next_in;
  logic          hit;
  logic          same_prev;
  logic          same_next;
  logic signed [47:0] msum;
  logic          accept;
  logic          load;
  logic [CW-1:0] kx;
  logic [CW-1:0] tx;
  logic [CW-1:0] ix;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign load     = (state == S_FIN) && (!out_valid || !out_stall);
  assign last     = (k == KW'(DEPTH - 1));
  assign kx       = CW'(k);
  assign tx       = CW'(total);
  assign ix       = CW'(idx_r);
  assign in_tab   = kx < tx;
  assign at_tot   = kx == tx;
  assign next_in  = (kx + CW'(1)) < tx;

  // Cell control
  always_comb begin
    op.shift  = (state == S_SCAN) || (state == S_MERGE);
    op.sort   = (state == S_SORT) || (state == S_PACK);
    op.parity = k[0];
    if (state == S_PACK) begin
      op.key = KEY_DEAD;
    end else if (cmd == CMD_SORTCAT) begin
      op.key = KEY_CAT;
    end else begin
      op.key = KEY_CNT;
    end
  end

  // Build the entry fed into the tail during a ring pass
  always_comb begin
    hit       = in_tab && !found && (q[0].cat == cat_r);
    same_prev = (k != '0) && (acc_cat == q[0].cat);
    same_next = next_in && (q[1].cat == q[0].cat);
    msum      = same_prev ? sat_add(acc_cnt, q[0].cnt) : q[0].cnt;
    ins       = q[0];
    if (state == S_MERGE) begin
      if (in_tab) begin
        ins.cnt  = msum;
        ins.dead = same_next;
      end
    end else begin
      case (cmd)
        CMD_ADD, CMD_SET: begin
          if (hit) begin
            ins.cnt = (cmd == CMD_ADD) ? sat_add(q[0].cnt, cnt_r) : cnt_r;
          end else if (at_tot && !found) begin
            ins.cat = cat_r;
            ins.cnt = cnt_r;
          end
        end
        CMD_APPEND: begin
          if (at_tot) begin
            ins.cat = cat_r;
            ins.cnt = cnt_r;
          end
        end
        CMD_ZERO: begin
          if (in_tab) begin
            ins.cnt = '0;
          end
        end
        default: begin
          ins = q[0];
        end
      endcase
    end
  end

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t rgt;
    entry_t lft;
    logic   sin;
    if (i == DEPTH - 1) begin : g_tail
      assign rgt = ins;
    end else begin : g_mid
      assign rgt = q[i+1];
    end
    if (i == 0) begin : g_head
      assign lft = q[0];
      assign sin = 1'b0;
    end else begin : g_rest
      assign lft = q[i-1];
      assign sin = swp[i-1];
    end
    cctab_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
      .clk      (clk),
      .op       (op),
      .total    (total),
      .right    (rgt),
      .left     (lft),
      .swap_in  (sin),
      .swap_out (swp[i]),
      .q        (q[i])
    );
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      out_valid <= 1'b0;
      k         <= '0;
      found     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd   <= command;
            cat_r <= entry_category;
            cnt_r <= entry_count;
            idx_r <= entry_index;
            k     <= '0;
            found <= 1'b0;
            alive <= '0;
            st_r  <= ST_DONE;
            rcat  <= '0;
            rcnt  <= '0;
            case (command)
              CMD_CLEAR: begin
                total <= '0;
                state <= S_FIN;
              end
              CMD_SORTCAT, CMD_SORTCNT: begin
                state <= (total > TW'(1)) ? S_SORT : S_FIN;
              end
              default: begin
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          k <= k + KW'(1);
          if (hit) begin
            found <= 1'b1;
          end
          if ((cmd == CMD_READ) && (kx == ix) && in_tab) begin
            rcat <= q[0].cat;
            rcnt <= q[0].cnt;
          end
          if (last) begin
            state <= S_FIN;
            case (cmd)
              CMD_ADD, CMD_SET: begin
                if (found || hit) begin
                  st_r <= ST_UPDATED;
                end else if (tx < CW'(DEPTH)) begin
                  st_r  <= ST_APPENDED;
                  total <= total + TW'(1);
                end else begin
                  st_r <= ST_FULL;
                end
              end
              CMD_APPEND: begin
                if (tx < CW'(DEPTH)) begin
                  st_r  <= ST_APPENDED;
                  total <= total + TW'(1);
                end else begin
                  st_r <= ST_FULL;
                end
              end
              CMD_READ: begin
                st_r <= (ix < tx) ? ST_DONE : ST_RANGE;
              end
              default: begin
                st_r <= ST_DONE;
              end
            endcase
          end
        end
        S_SORT: begin
          k <= last ? '0 : k + KW'(1);
          if (last) begin
            state <= (cmd == CMD_SORTCAT) ? S_MERGE : S_FIN;
          end
        end
        S_MERGE: begin
          k <= last ? '0 : k + KW'(1);
          if (in_tab) begin
            acc_cat <= q[0].cat;
            acc_cnt <= msum;
            if (!same_next) begin
              alive <= alive + TW'(1);
            end
          end
          if (last) begin
            state <= S_PACK;
          end
        end
        S_PACK: begin
          k <= k + KW'(1);
          if (last) begin
            total <= alive;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      status        <= st_r;
      read_category <= rcat;
      read_count    <= rcnt;
      entries_used  <= 9'(total);
    end
  end

endmodule

// ----- rtl/cctab_chk.sv -----
// ----------------------------------------------------------------------------
// cctab_chk
// Port-level checks for the histogram table, bound to the top level.
// ----------------------------------------------------------------------------
module cctab_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         status,
  input logic signed [31:0] read_category,
  input logic signed [47:0] read_count,
  input logic [8:0]         entries_used
);
  import cctab_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(entries_used))
    else $error("stalled item changed");

  // Out-of-range read carries zero payload
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_RANGE) |-> (read_category == 0) && (read_count == 0))
    else $error("out-of-range read with data");

  // Append leaves a nonempty table
  a_app: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_APPENDED) |-> (entries_used != 9'd0))
    else $error("append with empty table");

  // An accepted item leaves the input stalled in the next cycle while busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // Reset empties the output
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind category_count_histogram_table_unit cctab_chk u_chk (.*);
